// File: src/plb_pkg.sv
// Shared types and constants for the partition load balancer.
package plb_pkg;

   localparam int MAX_PARTS_DEF = 64;
   localparam int HIT_W = 32;
   localparam int SUM_W = 48;
   localparam int THR_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REQ_UPDATE = 3'd0,
      REQ_TIMED  = 3'd1,
      REQ_FORCED = 3'd2,
      REQ_READ   = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_SPLIT = 2'd1,
      ACT_MERGE = 2'd2
   } act_type;

   typedef enum logic [2:0] {
      CSR_INIT_PARTS = 3'd0,
      CSR_MIN_PARTS  = 3'd1,
      CSR_MAX_PARTS  = 3'd2,
      CSR_LOAD_THR   = 3'd3,
      CSR_SPLIT_THR  = 3'd4,
      CSR_MERGE_THR  = 3'd5,
      CSR_INTERVAL   = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      RD_REQ, RD_SCAN, RD_LEFT, RD_RIGHT, RD_MIN, RD_NB
   } rd_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_UPD_RD, ST_UPD_WR, ST_RD_RD, ST_RD_CAP, ST_CLR,
      ST_ADP_INIT, ST_ADP_SCAN, ST_ADP_DRAIN, ST_ADP_MUL, ST_ADP_DEC, ST_SPLIT,
      ST_MRG_RL, ST_MRG_RR, ST_MRG_PICK, ST_MRG_RMIN, ST_MRG_RNB, ST_MRG_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [HIT_W-1:0] hit;
      logic [SUM_W-1:0] lat;
      logic [SUM_W-1:0] size;
   } stats_type;

   typedef struct packed {
      logic       latch;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       scan_init;
      logic       scan_step;
      logic       mul;
      logic       split;
      logic       lat_left;
      logic       pick;
      logic       lat_min;
      logic       upd_wr;
      logic       mrg_wr;
      logic       cap;
      logic       clear_all;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         idx_ok;
      logic         go;
      logic         n_le1;
      logic         scan_last;
      logic         imb;
      logic         can_split;
      logic         can_merge;
      logic         nb_is_min;
      logic         rsp_free;
   } stat_type;

endpackage

// File: src/plb_ctrl.sv
// Request sequencer for the partition load balancer.
module plb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  plb_pkg::stat_type stat,
   output plb_pkg::cmd_type  cmd
);
   import plb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (stat.req_kind)
               REQ_UPDATE: state_in = stat.idx_ok ? ST_UPD_RD : ST_DONE;
               REQ_TIMED, REQ_FORCED:
                  state_in = (stat.go && !stat.n_le1) ? ST_ADP_INIT : ST_DONE;
               REQ_READ:   state_in = stat.idx_ok ? ST_RD_RD : ST_DONE;
               REQ_CLEAR:  state_in = ST_CLR;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_UPD_RD:    state_in = ST_UPD_WR;
         ST_UPD_WR:    state_in = ST_DONE;
         ST_RD_RD:     state_in = ST_RD_CAP;
         ST_RD_CAP:    state_in = ST_DONE;
         ST_CLR:       state_in = ST_DONE;
         ST_ADP_INIT:  state_in = ST_ADP_SCAN;
         ST_ADP_SCAN:  if (stat.scan_last) state_in = ST_ADP_DRAIN;
         ST_ADP_DRAIN: state_in = ST_ADP_MUL;
         ST_ADP_MUL:   state_in = ST_ADP_DEC;
         ST_ADP_DEC: begin
            if (!stat.imb) state_in = ST_DONE;
            else if (stat.can_split) state_in = ST_SPLIT;
            else if (stat.can_merge) state_in = ST_MRG_RL;
            else state_in = ST_DONE;
         end
         ST_SPLIT:     state_in = ST_DONE;
         ST_MRG_RL:    state_in = ST_MRG_RR;
         ST_MRG_RR:    state_in = ST_MRG_PICK;
         ST_MRG_PICK:  state_in = stat.nb_is_min ? ST_DONE : ST_MRG_RMIN;
         ST_MRG_RMIN:  state_in = ST_MRG_RNB;
         ST_MRG_RNB:   state_in = ST_MRG_WR;
         ST_MRG_WR:    state_in = ST_DONE;
         ST_DONE:      if (stat.rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_REQ;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ST_UPD_RD:   cmd.rd_en = 1'b1;
         ST_UPD_WR:   cmd.upd_wr = 1'b1;
         ST_RD_RD:    cmd.rd_en = 1'b1;
         ST_RD_CAP:   cmd.cap = 1'b1;
         ST_CLR:      cmd.clear_all = 1'b1;
         ST_ADP_INIT: cmd.scan_init = 1'b1;
         ST_ADP_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_SCAN;
            cmd.scan_step = 1'b1;
         end
         ST_ADP_MUL:  cmd.mul = 1'b1;
         ST_SPLIT:    cmd.split = 1'b1;
         ST_MRG_RL: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_LEFT;
         end
         ST_MRG_RR: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_RIGHT;
            cmd.lat_left = 1'b1;
         end
         ST_MRG_PICK: cmd.pick = 1'b1;
         ST_MRG_RMIN: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_MIN;
         end
         ST_MRG_RNB: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_NB;
            cmd.lat_min = 1'b1;
         end
         ST_MRG_WR:   cmd.mrg_wr = 1'b1;
         ST_DONE:     cmd.load_out = stat.rsp_free;
         default:     cmd = '0;
      endcase
   end

endmodule

// File: src/plb_datapath.sv
// Stats memory, configuration registers, scan and decision arithmetic.
module plb_datapath #(
   parameter int MAX_PARTS = plb_pkg::MAX_PARTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  plb_pkg::cmd_type              cmd,
   output plb_pkg::stat_type             stat,
   input  logic                          csr_we,
   input  logic [plb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [plb_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [2:0]                    req_type,
   input  logic [5:0]                    req_part_index,
   input  logic [23:0]                   req_latency_us,
   input  logic [15:0]                   req_data_bytes,
   input  logic [31:0]                   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [1:0]                    rsp_action,
   output logic [5:0]                    rsp_target_part,
   output logic [5:0]                    rsp_other_part,
   output logic [6:0]                    rsp_active_parts,
   output logic [31:0]                   rsp_hit_count,
   output logic [47:0]                   rsp_latency_sum,
   output logic [47:0]                   rsp_size_sum
);
   import plb_pkg::*;

   localparam int IDX_W = $clog2(MAX_PARTS);
   localparam int CNT_W = $clog2(MAX_PARTS + 1);
   localparam int TOT_W = HIT_W + CNT_W;
   localparam int PM_W  = HIT_W + CNT_W;
   localparam int PT_W  = TOT_W + THR_W + 1;
   localparam int CMP_W = PT_W + 1;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [6:0] v);
      logic [CNT_W-1:0] r;
      if (v == 7'd0) r = CNT_W'(1);
      else if (int'(v) > MAX_PARTS) r = CNT_W'(MAX_PARTS);
      else r = CNT_W'(v);
      return r;
   endfunction

   // configuration
   logic [6:0]        min_parts_ff, max_parts_ff;
   logic [THR_W-1:0]  load_thr_ff, split_thr_ff, merge_thr_ff;
   logic [31:0]       interval_ff;
   logic [CNT_W-1:0]  part_count_ff;
   logic [31:0]       last_adapt_ff;

   // latched request
   req_kind_type      kind_ff;
   logic [5:0]        idx_ff;
   logic [23:0]       lat_ff;
   logic [15:0]       dat_ff;
   logic              go_ff;

   // stats storage
   stats_type         mem [MAX_PARTS];
   logic [MAX_PARTS-1:0] valid_ff;
   stats_type         rd_data_ff;
   logic              rd_vld_ff;
   stats_type         eff;

   // scan
   logic [CNT_W-1:0]  ptr_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [TOT_W-1:0]  tot_ff;
   logic [HIT_W-1:0]  max_c_ff;
   logic [IDX_W-1:0]  max_i_ff;
   logic [HIT_W:0]    min_c_ff;
   logic [IDX_W-1:0]  min_i_ff;
   logic [PM_W-1:0]   pmax_ff, pmin_ff;
   logic [PT_W-1:0]   pload_ff, psplit_ff, pmerge_ff;

   // merge
   logic [HIT_W-1:0]  left_hit_ff;
   logic [IDX_W-1:0]  nb_ff;
   stats_type         min_st_ff;
   logic [IDX_W-1:0]  left_idx, right_idx, nb_pick, req_addr, rd_addr;

   // result
   logic              res_acc_ff;
   act_type           res_act_ff;
   logic [IDX_W-1:0]  res_tgt_ff, res_oth_ff;
   stats_type         res_st_ff;
   logic              rsp_valid_ff;
   logic              out_acc_ff;
   logic [1:0]        out_act_ff;
   logic [5:0]        out_tgt_ff, out_oth_ff;
   logic [6:0]        out_parts_ff;
   stats_type         out_st_ff;

   logic              gate_pass;
   logic [HIT_W:0]    hsum;
   logic [SUM_W:0]    lsum, ssum;
   stats_type         upd_st, mrg_st;
   logic [CMP_W-1:0]  lhs_max, lhs_min;

   assign gate_pass = (req_now_ms - last_adapt_ff) >= interval_ff;
   assign eff = rd_vld_ff ? rd_data_ff : '0;
   assign req_addr = IDX_W'(idx_ff);

   assign left_idx  = (min_i_ff == '0) ? IDX_W'(part_count_ff - CNT_W'(1))
                                       : min_i_ff - IDX_W'(1);
   assign right_idx = ((CNT_W'(min_i_ff) + CNT_W'(1)) == part_count_ff) ? '0
                                       : min_i_ff + IDX_W'(1);
   assign nb_pick = (left_hit_ff <= eff.hit) ? left_idx : right_idx;

   always_comb begin
      case (cmd.rd_sel)
         RD_SCAN:  rd_addr = ptr_ff[IDX_W-1:0];
         RD_LEFT:  rd_addr = left_idx;
         RD_RIGHT: rd_addr = right_idx;
         RD_MIN:   rd_addr = min_i_ff;
         RD_NB:    rd_addr = nb_ff;
         default:  rd_addr = req_addr;
      endcase
   end

   // saturating update of one entry
   always_comb begin
      hsum = {1'b0, eff.hit} + (HIT_W+1)'(1);
      lsum = {1'b0, eff.lat} + (SUM_W+1)'(lat_ff);
      ssum = {1'b0, eff.size} + (SUM_W+1)'(dat_ff);
      upd_st.hit  = hsum[HIT_W] ? '1 : hsum[HIT_W-1:0];
      upd_st.lat  = lsum[SUM_W] ? '1 : lsum[SUM_W-1:0];
      upd_st.size = ssum[SUM_W] ? '1 : ssum[SUM_W-1:0];
   end

   // saturating merge of neighbor into least loaded entry
   logic [HIT_W:0] mh;
   logic [SUM_W:0] ml, ms;
   always_comb begin
      mh = {1'b0, min_st_ff.hit} + {1'b0, eff.hit};
      ml = {1'b0, min_st_ff.lat} + {1'b0, eff.lat};
      ms = {1'b0, min_st_ff.size} + {1'b0, eff.size};
      mrg_st.hit  = mh[HIT_W] ? '1 : mh[HIT_W-1:0];
      mrg_st.lat  = ml[SUM_W] ? '1 : ml[SUM_W-1:0];
      mrg_st.size = ms[SUM_W] ? '1 : ms[SUM_W-1:0];
   end

   assign lhs_max = CMP_W'({pmax_ff, 8'd0});
   assign lhs_min = CMP_W'({pmin_ff, 8'd0});

   always_comb begin
      stat.req_kind  = kind_ff;
      stat.idx_ok    = (int'(idx_ff) < int'(part_count_ff)) && (int'(idx_ff) < MAX_PARTS);
      stat.go        = go_ff;
      stat.n_le1     = part_count_ff <= CNT_W'(1);
      stat.scan_last = (ptr_ff + CNT_W'(1)) == part_count_ff;
      stat.imb       = lhs_max > CMP_W'(pload_ff);
      stat.can_split = (int'(part_count_ff) < int'(max_parts_ff))
                       && (int'(part_count_ff) < MAX_PARTS)
                       && (lhs_max > CMP_W'(psplit_ff));
      stat.can_merge = (int'(part_count_ff) > int'(min_parts_ff))
                       && (lhs_min < CMP_W'(pmerge_ff));
      stat.nb_is_min = nb_pick == min_i_ff;
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // memory array
   always_ff @(posedge clock) begin
      if (cmd.upd_wr) begin
         mem[req_addr] <= upd_st;
      end else if (cmd.mrg_wr) begin
         mem[min_i_ff] <= mrg_st;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) rd_vld_ff <= valid_ff[rd_addr];
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (cmd.upd_wr) begin
            valid_ff[req_addr] <= 1'b1;
         end else if (cmd.split) begin
            valid_ff[max_i_ff] <= 1'b0;
            valid_ff[part_count_ff[IDX_W-1:0]] <= 1'b0;
         end else if (cmd.mrg_wr) begin
            valid_ff[min_i_ff] <= 1'b1;
            valid_ff[nb_ff] <= 1'b0;
         end
      end
   end

   // configuration, count and gate time
   always_ff @(posedge clock) begin
      if (reset) begin
         min_parts_ff  <= 7'd1;
         max_parts_ff  <= 7'd64;
         load_thr_ff   <= THR_W'(128);
         split_thr_ff  <= THR_W'(384);
         merge_thr_ff  <= THR_W'(128);
         interval_ff   <= 32'd1000;
         part_count_ff <= clamp_count(7'd4);
         last_adapt_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_INIT_PARTS: part_count_ff <= clamp_count(csr_wdata[6:0]);
               CSR_MIN_PARTS: min_parts_ff <= csr_wdata[6:0];
               CSR_MAX_PARTS: max_parts_ff <= csr_wdata[6:0];
               CSR_LOAD_THR:  load_thr_ff  <= csr_wdata[THR_W-1:0];
               CSR_SPLIT_THR: split_thr_ff <= csr_wdata[THR_W-1:0];
               CSR_MERGE_THR: merge_thr_ff <= csr_wdata[THR_W-1:0];
               CSR_INTERVAL:  interval_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.split) part_count_ff <= part_count_ff + CNT_W'(1);
         if (cmd.mrg_wr) part_count_ff <= part_count_ff - CNT_W'(1);
         if (cmd.latch && req_type == REQ_TIMED && gate_pass) last_adapt_ff <= req_now_ms;
      end
   end

   // request latch, scan and result registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff    <= req_kind_type'(req_type);
         idx_ff     <= req_part_index;
         lat_ff     <= req_latency_us;
         dat_ff     <= req_data_bytes;
         go_ff      <= (req_type == REQ_FORCED) || (req_type == REQ_TIMED && gate_pass);
         res_acc_ff <= (req_type == REQ_FORCED) || (req_type == REQ_TIMED && gate_pass);
         res_act_ff <= ACT_NONE;
         res_tgt_ff <= '0;
         res_oth_ff <= '0;
         res_st_ff  <= '0;
      end
      if (cmd.upd_wr) res_acc_ff <= 1'b1;
      if (cmd.cap) res_st_ff <= eff;
      if (cmd.split) begin
         res_act_ff <= ACT_SPLIT;
         res_tgt_ff <= max_i_ff;
         res_oth_ff <= part_count_ff[IDX_W-1:0];
      end
      if (cmd.mrg_wr) begin
         res_act_ff <= ACT_MERGE;
         res_tgt_ff <= min_i_ff;
         res_oth_ff <= nb_ff;
      end
      if (cmd.scan_init) begin
         ptr_ff   <= '0;
         tot_ff   <= '0;
         max_c_ff <= '0;
         max_i_ff <= '0;
         min_c_ff <= {1'b1, {HIT_W{1'b0}}};
         min_i_ff <= '0;
      end
      if (cmd.scan_step) ptr_ff <= ptr_ff + CNT_W'(1);
      pend_idx_ff <= ptr_ff[IDX_W-1:0];
      // fold in the entry read in the cycle before
      if (pend_ff) begin
         tot_ff <= tot_ff + TOT_W'(eff.hit);
         if (eff.hit > max_c_ff) begin
            max_c_ff <= eff.hit;
            max_i_ff <= pend_idx_ff;
         end
         if ({1'b0, eff.hit} < min_c_ff) begin
            min_c_ff <= {1'b0, eff.hit};
            min_i_ff <= pend_idx_ff;
         end
      end
      if (cmd.mul) begin
         pmax_ff   <= PM_W'(max_c_ff) * PM_W'(part_count_ff);
         pmin_ff   <= PM_W'(min_c_ff[HIT_W-1:0]) * PM_W'(part_count_ff);
         pload_ff  <= PT_W'(tot_ff) * (PT_W'(load_thr_ff) + PT_W'(256));
         psplit_ff <= PT_W'(tot_ff) * PT_W'(split_thr_ff);
         pmerge_ff <= PT_W'(tot_ff) * PT_W'(merge_thr_ff);
      end
      if (cmd.lat_left) left_hit_ff <= eff.hit;
      if (cmd.pick) nb_ff <= nb_pick;
      if (cmd.lat_min) min_st_ff <= eff;
      if (cmd.load_out) begin
         out_acc_ff   <= res_acc_ff;
         out_act_ff   <= res_act_ff;
         out_tgt_ff   <= 6'(res_tgt_ff);
         out_oth_ff   <= 6'(res_oth_ff);
         out_parts_ff <= 7'(part_count_ff);
         out_st_ff    <= res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.scan_step;
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = out_acc_ff;
   assign rsp_action       = out_act_ff;
   assign rsp_target_part  = out_tgt_ff;
   assign rsp_other_part   = out_oth_ff;
   assign rsp_active_parts = out_parts_ff;
   assign rsp_hit_count    = out_st_ff.hit;
   assign rsp_latency_sum  = out_st_ff.lat;
   assign rsp_size_sum     = out_st_ff.size;

endmodule

// File: src/partition_load_balancer.sv
// Top level of the partition load balancer.
// One request at a time. An adapt request that runs scans the hit counts of all
// n active partitions through the single read port of the stats memory, and a
// merge needs further reads of that port. The result register frees the
// request side, so a new request is taken while a result waits; it stalls only
// when a second result is ready before the first one is taken. Statistics are
// cleared at reset and by a clear request through per-entry valid bits.
module partition_load_balancer #(
   parameter int MAX_PARTS = plb_pkg::MAX_PARTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_type,
   input  logic [5:0]                    req_part_index,
   input  logic [23:0]                   req_latency_us,
   input  logic [15:0]                   req_data_bytes,
   input  logic [31:0]                   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [1:0]                    rsp_action,
   output logic [5:0]                    rsp_target_part,
   output logic [5:0]                    rsp_other_part,
   output logic [6:0]                    rsp_active_parts,
   output logic [31:0]                   rsp_hit_count,
   output logic [47:0]                   rsp_latency_sum,
   output logic [47:0]                   rsp_size_sum,
   input  logic                          csr_we,
   input  logic [plb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [plb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import plb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   plb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   plb_datapath #(.MAX_PARTS(MAX_PARTS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_type         (req_type),
      .req_part_index   (req_part_index),
      .req_latency_us   (req_latency_us),
      .req_data_bytes   (req_data_bytes),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_action       (rsp_action),
      .rsp_target_part  (rsp_target_part),
      .rsp_other_part   (rsp_other_part),
      .rsp_active_parts (rsp_active_parts),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_latency_sum  (rsp_latency_sum),
      .rsp_size_sum     (rsp_size_sum)
   );

   a_action_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_NONE |-> rsp_accepted)
      else $error("adapt action reported without accepted");

   a_split_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_SPLIT || rsp_action == ACT_MERGE)
      |-> rsp_target_part != rsp_other_part)
      else $error("adapt action names one partition twice");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   a_parts_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_active_parts != 7'd0)
      else $error("active partition count is zero");

endmodule

// File: tb/sv/partition_load_balancer_tb.sv
// Self-checking testbench for the partition load balancer.
`timescale 1ns / 1ps

module partition_load_balancer_tb;
   import plb_pkg::*;

   localparam int NPARTS = 64;
   localparam logic [2:0] REQ_BAD_LO = 3'(REQ_CLEAR) + 3'd1;
   localparam logic [31:0] HIT_SAT = 32'hFFFF_FFFF;
   localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      bit        accepted;
      bit [1:0]  action;
      bit [5:0]  target;
      bit [5:0]  other;
      bit [6:0]  parts;
      bit [31:0] hits;
      bit [47:0] lat;
      bit [47:0] size;
   } outcome_type;

   class balance_scoreboard;
      bit [31:0] hit_cnt[NPARTS];
      bit [47:0] lat_sum[NPARTS];
      bit [47:0] size_sum[NPARTS];
      bit [6:0]  parts;
      bit [31:0] last_adapt;
      bit [6:0]  init_p, min_p, max_p;
      bit [15:0] load_thr, split_thr, merge_thr;
      bit [31:0] interval;
      outcome_type outcome_q[$];
      int        errors, checked, splits, merges;

      function void wipe();
         for (int i = 0; i < NPARTS; i++) begin
            hit_cnt[i] = '0;
            lat_sum[i] = '0;
            size_sum[i] = '0;
         end
      endfunction

      function void load_parts();
         parts = (init_p < 1) ? 7'd1 : (init_p > NPARTS) ? 7'(NPARTS) : init_p;
      endfunction

      function new();
         wipe();
         init_p = 4; min_p = 1; max_p = 64;
         load_thr = 128; split_thr = 384; merge_thr = 128;
         interval = 1000; last_adapt = 0;
         load_parts();
      endfunction

      function void configure(csr_idx_type idx, bit [31:0] val);
         case (idx)
            CSR_INIT_PARTS: begin
               init_p = val[6:0];
               load_parts();
            end
            CSR_MIN_PARTS: min_p = val[6:0];
            CSR_MAX_PARTS: max_p = val[6:0];
            CSR_LOAD_THR:  load_thr = val[15:0];
            CSR_SPLIT_THR: split_thr = val[15:0];
            CSR_MERGE_THR: merge_thr = val[15:0];
            CSR_INTERVAL:  interval = val;
            default: ;
         endcase
      endfunction

      function bit [47:0] sat48(bit [47:0] a, bit [47:0] b);
         bit [48:0] s;
         s = {1'b0, a} + b;
         return s[48] ? SUM_SAT : s[47:0];
      endfunction

      function bit [31:0] sat32(bit [31:0] a, bit [31:0] b);
         bit [32:0] s;
         s = {1'b0, a} + b;
         return s[32] ? HIT_SAT : s[31:0];
      endfunction

      function void clear_one(int i);
         hit_cnt[i] = '0;
         lat_sum[i] = '0;
         size_sum[i] = '0;
      endfunction

      // scan hit counts and rebalance; fills action and partition pair
      function void rebalance(ref outcome_type o);
         longint unsigned total, max_c, min_c, n;
         int max_i, min_i, left, right, nb, eff_max;
         n = parts;
         total = 0; max_c = 0; min_c = 64'h1_0000_0000; max_i = 0; min_i = 0;
         if (n <= 1) return;
         for (int i = 0; i < n; i++) begin
            total += hit_cnt[i];
            if (hit_cnt[i] > max_c) begin
               max_c = hit_cnt[i];
               max_i = i;
            end
            if (hit_cnt[i] < min_c) begin
               min_c = hit_cnt[i];
               min_i = i;
            end
         end
         if (!(max_c * n * 256 > total * (256 + longint'(load_thr)))) return;
         eff_max = (max_p > NPARTS) ? NPARTS : max_p;
         if (n < eff_max && max_c * n * 256 > total * longint'(split_thr)) begin
            clear_one(max_i);
            clear_one(int'(n));
            parts = 7'(n + 1);
            o.action = ACT_SPLIT;
            o.target = 6'(max_i);
            o.other = 6'(n);
            return;
         end
         if (n > min_p && min_c * n * 256 < total * longint'(merge_thr)) begin
            left = (min_i > 0) ? min_i - 1 : int'(n) - 1;
            right = (min_i + 1) % int'(n);
            nb = (hit_cnt[left] <= hit_cnt[right]) ? left : right;
            if (nb == min_i) return;
            hit_cnt[min_i] = sat32(hit_cnt[min_i], hit_cnt[nb]);
            lat_sum[min_i] = sat48(lat_sum[min_i], lat_sum[nb]);
            size_sum[min_i] = sat48(size_sum[min_i], size_sum[nb]);
            clear_one(nb);
            parts = 7'(n - 1);
            o.action = ACT_MERGE;
            o.target = 6'(min_i);
            o.other = 6'(nb);
         end
      endfunction

      function void note(bit [2:0] kind, bit [5:0] idx, bit [23:0] lat,
                         bit [15:0] dat, bit [31:0] now_ms);
         outcome_type o;
         o = '{default: 0};
         case (kind)
            REQ_UPDATE: if (idx < parts) begin
               hit_cnt[idx] = sat32(hit_cnt[idx], 1);
               lat_sum[idx] = sat48(lat_sum[idx], 48'(lat));
               size_sum[idx] = sat48(size_sum[idx], 48'(dat));
               o.accepted = 1;
            end
            REQ_TIMED, REQ_FORCED: begin
               if (kind == REQ_FORCED || 32'(now_ms - last_adapt) >= interval) begin
                  if (kind == REQ_TIMED) last_adapt = now_ms;
                  o.accepted = 1;
                  rebalance(o);
               end
            end
            REQ_READ: if (idx < parts) begin
               o.hits = hit_cnt[idx];
               o.lat = lat_sum[idx];
               o.size = size_sum[idx];
            end
            REQ_CLEAR: wipe();
            default: ;
         endcase
         o.parts = parts;
         outcome_q.insert(outcome_q.size(), o);
      endfunction

      function void cmp(string name, longint unsigned exp, longint unsigned act);
         if (exp != act) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            errors++;
         end
      endfunction

      function void check(outcome_type a);
         outcome_type e;
         if (outcome_q.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
         end
         e = outcome_q.pop_front();
         checked++;
         if (e.action == ACT_SPLIT) splits++;
         if (e.action == ACT_MERGE) merges++;
         cmp("accepted", e.accepted, a.accepted);
         cmp("action", e.action, a.action);
         cmp("target_part", e.target, a.target);
         cmp("other_part", e.other, a.other);
         cmp("active_parts", e.parts, a.parts);
         cmp("hit_count", e.hits, a.hits);
         cmp("latency_sum", e.lat, a.lat);
         cmp("size_sum", e.size, a.size);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [2:0] req_type = '0;
   logic [5:0] req_part_index = '0;
   logic [23:0] req_latency_us = '0;
   logic [15:0] req_data_bytes = '0;
   logic [31:0] req_now_ms = '0;
   logic rsp_valid, rsp_ready = 0;
   logic rsp_accepted;
   logic [1:0] rsp_action;
   logic [5:0] rsp_target_part, rsp_other_part;
   logic [6:0] rsp_active_parts;
   logic [31:0] rsp_hit_count;
   logic [47:0] rsp_latency_sum, rsp_size_sum;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   balance_scoreboard board = new();
   int gap_pct = 0, stall_pct = 0;
   bit [31:0] clock_ms = 0;
   int sent = 0;

   partition_load_balancer uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check(outcome_type'{rsp_accepted, rsp_action, rsp_target_part,
                                   rsp_other_part, rsp_active_parts, rsp_hit_count,
                                   rsp_latency_sum, rsp_size_sum});
   end

   task automatic send(bit [2:0] kind, bit [5:0] idx, bit [23:0] lat, bit [15:0] dat,
                       bit [31:0] now_ms);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_part_index <= idx;
      req_latency_us <= lat;
      req_data_bytes <= dat;
      req_now_ms <= now_ms;
      do @(posedge clock); while (!req_ready);
      board.note(kind, idx, lat, dat, now_ms);
      sent++;
      @(negedge clock);
   endtask

   // drain all results, then wait idle with req_valid low
   task automatic settle();
      req_valid <= 0;
      while (board.outcome_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, bit [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      board.configure(idx, val);
      @(negedge clock);
   endtask

   task automatic random_request(int hot);
      int pick;
      bit [5:0] idx;
      bit [23:0] lat;
      pick = $urandom_range(99);
      if (pick < 15) idx = 6'($urandom_range(63));
      else if (pick < 60) idx = 6'(hot);
      else idx = 6'($urandom_range(board.parts));
      lat = ($urandom_range(19) == 0) ? 24'hFF_FFFF : 24'($urandom);
      clock_ms += $urandom_range(400);
      pick = $urandom_range(99);
      if (pick < 55) send(REQ_UPDATE, idx, lat, 16'($urandom), $urandom);
      else if (pick < 70) send(REQ_FORCED, idx, lat, 16'($urandom), $urandom);
      else if (pick < 80)
         send(REQ_TIMED, idx, lat, 16'($urandom),
              ($urandom_range(9) == 0) ? $urandom : clock_ms);
      else if (pick < 95) send(REQ_READ, idx, lat, 16'($urandom), $urandom);
      else if (pick < 97) send(REQ_CLEAR, idx, lat, 16'($urandom), $urandom);
      else send(REQ_BAD_LO + 3'($urandom_range(2)), idx, lat, 16'($urandom), $urandom);
   endtask

   task automatic random_phase(int gap, int stall, int count);
      int hot;
      gap_pct = gap;
      stall_pct = stall;
      hot = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) hot = $urandom_range(board.parts);
         random_request(hot);
      end
      settle();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: field extremes, gating, split, clear, unknown types
      send(REQ_UPDATE, 0, 24'hFF_FFFF, 16'hFFFF, 0);
      send(REQ_UPDATE, 63, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send(REQ_READ, 0, 0, 0, 0);
      send(REQ_READ, 63, 0, 0, 0);
      send(REQ_TIMED, 0, 0, 0, 0);
      send(REQ_TIMED, 0, 0, 0, 1000);
      send(REQ_TIMED, 0, 0, 0, 500);
      for (int i = 0; i < 6; i++) send(REQ_UPDATE, 2, 24'(i), 16'(i), 0);
      send(REQ_FORCED, 0, 0, 0, 0);
      send(REQ_READ, 2, 0, 0, 0);
      send(REQ_UPDATE, 1, 1, 1, 0);
      send(REQ_FORCED, 0, 0, 0, 0);
      send(REQ_CLEAR, 0, 0, 0, 0);
      send(REQ_FORCED, 0, 0, 0, 0);
      send(REQ_BAD_LO, 0, 0, 0, 0);
      send(3'b111, 63, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      settle();

      random_phase(0, 0, 340);

      // eager split and merge, full count range
      csr_write(CSR_INIT_PARTS, 64);
      csr_write(CSR_MAX_PARTS, 64);
      csr_write(CSR_LOAD_THR, 0);
      csr_write(CSR_SPLIT_THR, 0);
      csr_write(CSR_MERGE_THR, 16'hFFFF);
      csr_write(CSR_INTERVAL, 0);
      random_phase(72, 0, 340);

      // count clamped up from zero, max limited, merges favored
      csr_write(CSR_INIT_PARTS, 0);
      csr_write(CSR_MIN_PARTS, 1);
      csr_write(CSR_MAX_PARTS, 127);
      csr_write(CSR_SPLIT_THR, 16'hFFFF);
      csr_write(CSR_MERGE_THR, 1024);
      csr_write(CSR_INTERVAL, 200);
      random_phase(0, 72, 340);

      // count clamped down, bounds block every change, long interval; then a mid-range setup
      csr_write(CSR_INIT_PARTS, 100);
      csr_write(CSR_MIN_PARTS, 64);
      csr_write(CSR_MAX_PARTS, 1);
      csr_write(CSR_LOAD_THR, 16'hFFFF);
      csr_write(CSR_INTERVAL, 32'hFFFF_FFFF);
      random_phase(33, 33, 170);
      csr_write(CSR_INIT_PARTS, 8);
      csr_write(CSR_MIN_PARTS, 2);
      csr_write(CSR_MAX_PARTS, 16);
      csr_write(CSR_LOAD_THR, 64);
      csr_write(CSR_SPLIT_THR, 300);
      csr_write(CSR_MERGE_THR, 200);
      csr_write(CSR_INTERVAL, 100);
      random_phase(33, 33, 170);

      $display("%0d requests sent, %0d results checked", sent, board.checked);
      $display("adapts seen: %0d splits, %0d merges", board.splits, board.merges);
      if (board.errors == 0 && board.outcome_q.size() == 0) begin
         $display("status: pass");
      end else begin
         if (board.outcome_q.size() != 0)
            $error("%0d results never arrived", board.outcome_q.size());
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
src/plb_pkg.sv
src/plb_ctrl.sv
src/plb_datapath.sv
src/partition_load_balancer.sv
tb/sv/partition_load_balancer_tb.sv
